[hdl/spfc_pkg.sv]
`default_nettype none
package spfc_pkg;

	// APB register map
	localparam int unsigned ADDR_W = 3;
	localparam logic [ADDR_W-1:0] ADDR_CRC_POLY = 3'd0;
	localparam logic [7:0] CRC_POLY_RESET = 8'h07;

	// mode byte flags
	localparam int unsigned MODE_TIME_FIRST = 3;
	localparam int unsigned MODE_MSB_FIRST = 2;
	localparam int unsigned MODE_CRC = 1;
	localparam int unsigned MODE_END = 0;

	// framing characters
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_B = 8'h42;
	localparam logic [7:0] CH_Y = 8'h59;
	localparam logic [7:0] CH_Z = 8'h5A;

	// packet layout
	localparam logic [3:0] IDX_SYNC0 = 4'd0;
	localparam logic [3:0] IDX_SYNC1 = 4'd1;
	localparam logic [3:0] IDX_MODE = 4'd2;
	localparam logic [3:0] IDX_NUM = 4'd3;
	localparam logic [3:0] IDX_DATA = 4'd4;
	localparam logic [3:0] IDX_DATA_END = 4'd11;
	localparam logic [3:0] IDX_TAIL = 4'd12;
	localparam logic [3:0] CRC_BYTES = 4'd8;

endpackage
`default_nettype wire

[hdl/spfc_item_if.sv]
`default_nettype none
interface spfc_item_if;
	logic        valid;
	logic        ready;
	logic [31:0] time_bits;
	logic [31:0] temp_bits;
	logic [7:0]  mode_byte;
	logic [7:0]  packet_number;

	modport source(output valid, output time_bits, output temp_bits, output mode_byte,
		output packet_number, input ready);
	modport sink(input valid, input time_bits, input temp_bits, input mode_byte,
		input packet_number, output ready);
endinterface
`default_nettype wire

[hdl/spfc_byte_if.sv]
`default_nettype none
interface spfc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;

	modport source(output valid, output out_byte, output last, input ready);
	modport sink(input valid, input out_byte, input last, output ready);
endinterface
`default_nettype wire

[hdl/sensor_packet_framer_crc8_top.sv]
// Sensor packet framer. Each sample item (time word, temperature word, mode byte,
// packet number) becomes one byte packet: 'A', 'B', mode, packet number, eight
// data bytes (temperature first unless mode bit 3, each word LSB first unless
// mode bit 2), then a CRC byte if mode bit 1 and 'Y','Z' if mode bit 0. The packet
// is 12 to 15 bytes and leaves on the packet channel one byte per cycle while
// the byte channel is ready, last set on its final byte. The next item is taken
// in the cycle the last byte of the current packet moves into the output
// register, so packets run back to back with no gap. The CRC (non-reflected,
// zero init, no final xor, polynomial from register crc_poly at address 0,
// reset 0x07) runs over time then temperature bytes, one byte per cycle,
// finishing after eight bytes, well before the CRC byte slot. crc_poly must
// be written over APB only while no packet is in flight; the block itself
// does not enforce this.
`default_nettype none
module sensor_packet_framer_crc8_top
	import spfc_pkg::*;
#(
	parameter int unsigned CRC_WIDTH = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	spfc_item_if.sink              sample,
	spfc_byte_if.source            packet,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready
);

	function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] j,
		input logic msb);
		logic [1:0] pos;
		pos = msb ? ~j : j;
		return 8'(w >> {pos, 3'b000});
	endfunction

	// one data byte through the CRC register, MSB first
	function automatic logic [CRC_WIDTH-1:0] crc_feed(input logic [CRC_WIDTH-1:0] crc_in,
		input logic [7:0] b, input logic [CRC_WIDTH-1:0] poly);
		logic [CRC_WIDTH-1:0] c;
		logic                 top;
		c = crc_in;
		for (int i = 7; i >= 0; i--) begin
			top = c[CRC_WIDTH-1] ^ b[i];
			c = c << 1;
			if (top) begin
				c = c ^ poly;
			end
		end
		return c;
	endfunction

	// config register
	logic [7:0] crc_poly_q;
	logic       cfg_wr;

	// packet being sent
	logic                 work_vld_q;
	logic [31:0]          time_q;
	logic [31:0]          temp_q;
	logic [7:0]           mode_q;
	logic [7:0]           num_q;
	logic [3:0]           idx_q;
	logic [CRC_WIDTH-1:0] crc_q;
	logic [3:0]           crc_cnt_q;

	// output register
	logic       out_vld_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	logic       take;
	logic       move;
	logic       out_free;
	logic       is_last;
	logic [3:0] last_idx;
	logic [3:0] data_k;
	logic [3:0] yz_pos;
	logic       sel_time;
	logic [7:0] cur_byte;
	logic [7:0] crc_in_byte;
	logic       crc_run;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr == ADDR_CRC_POLY) ? {24'd0, crc_poly_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_poly_q <= CRC_POLY_RESET;
		end else if (cfg_wr && paddr == ADDR_CRC_POLY) begin
			crc_poly_q <= pwdata[7:0];
		end
	end

	// handshake
	assign out_free     = !out_vld_q || packet.ready;
	assign move         = work_vld_q && out_free;
	assign last_idx     = IDX_DATA_END + 4'(mode_q[MODE_CRC]) + (mode_q[MODE_END] ? 4'd2 : 4'd0);
	assign is_last      = idx_q == last_idx;
	assign sample.ready = !work_vld_q || (move && is_last);
	assign take         = sample.valid && sample.ready;

	// byte selection
	assign data_k   = idx_q - IDX_DATA;
	assign sel_time = mode_q[MODE_TIME_FIRST] ^ data_k[2];
	assign yz_pos   = idx_q - IDX_TAIL - 4'(mode_q[MODE_CRC]);

	always_comb begin
		case (idx_q) inside
			IDX_SYNC0: cur_byte = CH_A;
			IDX_SYNC1: cur_byte = CH_B;
			IDX_MODE:  cur_byte = mode_q;
			IDX_NUM:   cur_byte = num_q;
			[IDX_DATA:IDX_DATA_END]: begin
				cur_byte = word_byte(sel_time ? time_q : temp_q, data_k[1:0],
					mode_q[MODE_MSB_FIRST]);
			end
			default: begin
				if (mode_q[MODE_CRC] && idx_q == IDX_TAIL) begin
					cur_byte = 8'(crc_q);
				end else if (yz_pos == 4'd0) begin
					cur_byte = CH_Y;
				end else begin
					cur_byte = CH_Z;
				end
			end
		endcase
	end

	// CRC covers time bytes then temperature bytes, one byte a cycle
	assign crc_run     = work_vld_q && (crc_cnt_q != CRC_BYTES);
	assign crc_in_byte = word_byte(crc_cnt_q[2] ? temp_q : time_q, crc_cnt_q[1:0],
		mode_q[MODE_MSB_FIRST]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_vld_q <= 1'b0;
			idx_q      <= '0;
			crc_cnt_q  <= '0;
		end else begin
			if (take) begin
				work_vld_q <= 1'b1;
				idx_q      <= '0;
			end else if (move && is_last) begin
				work_vld_q <= 1'b0;
			end else if (move) begin
				idx_q <= idx_q + 4'd1;
			end
			if (take) begin
				crc_cnt_q <= '0;
			end else if (crc_run) begin
				crc_cnt_q <= crc_cnt_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			time_q <= sample.time_bits;
			temp_q <= sample.temp_bits;
			mode_q <= sample.mode_byte;
			num_q  <= sample.packet_number;
			crc_q  <= '0;
		end else if (crc_run) begin
			crc_q <= crc_feed(crc_q, crc_in_byte, crc_poly_q[CRC_WIDTH-1:0]);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= work_vld_q;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_byte_q <= cur_byte;
			out_last_q <= is_last;
		end
	end

	assign packet.valid    = out_vld_q;
	assign packet.out_byte = out_byte_q;
	assign packet.last     = out_last_q;

endmodule
`default_nettype wire
